// ===== sv/hlg_pkg.sv =====
// Package for the hexagonal lattice gas collision block: candidate-set type and lookup.
package hlg_pkg;

  localparam int unsigned StateW = 6;
  localparam int unsigned RandW  = 16;

  typedef logic [StateW-1:0] state_t;

  // Up to three post-collision states, in ascending order, and how many are valid.
  typedef struct packed {
    logic [1:0] n;
    state_t     c0;
    state_t     c1;
    state_t     c2;
  } cand_set_t;

  // Occupancy with every particle reversed (rotate by three directions).
  function automatic state_t reverse_state(input state_t s);
    reverse_state = {s[2:0], s[5:3]};
  endfunction

  // Class of states sharing count and momentum with t. Only the zero-momentum
  // pairs/quads/triads and the single-plus-opposite-pair triples have more than one.
  function automatic cand_set_t cand_of(input state_t t);
    cand_set_t c;
    c.n  = 2'd1;
    c.c0 = t;
    c.c1 = t;
    c.c2 = t;
    case (t)
      6'd9, 6'd18, 6'd36: begin
        c.n = 2'd3; c.c0 = 6'd9;  c.c1 = 6'd18; c.c2 = 6'd36;
      end
      6'd27, 6'd45, 6'd54: begin
        c.n = 2'd3; c.c0 = 6'd27; c.c1 = 6'd45; c.c2 = 6'd54;
      end
      6'd21, 6'd42: begin
        c.n = 2'd2; c.c0 = 6'd21; c.c1 = 6'd42;
      end
      6'd19, 6'd37: begin
        c.n = 2'd2; c.c0 = 6'd19; c.c1 = 6'd37;
      end
      6'd26, 6'd44: begin
        c.n = 2'd2; c.c0 = 6'd26; c.c1 = 6'd44;
      end
      6'd11, 6'd38: begin
        c.n = 2'd2; c.c0 = 6'd11; c.c1 = 6'd38;
      end
      6'd25, 6'd52: begin
        c.n = 2'd2; c.c0 = 6'd25; c.c1 = 6'd52;
      end
      6'd13, 6'd22: begin
        c.n = 2'd2; c.c0 = 6'd13; c.c1 = 6'd22;
      end
      6'd41, 6'd50: begin
        c.n = 2'd2; c.c0 = 6'd41; c.c1 = 6'd50;
      end
      default: begin
        c.n = 2'd1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hex_lattice_gas_collision.sv =====
// Top level of the hexagonal lattice gas collision block.

// One cell enters per cycle unless out_stall backs up both stages: an input
// register holds the cell state and random value, a small lookup of the
// equivalent-state class plus a three-way pick feeds the output register.
// The two stages advance independently, so an input transfer is still taken
// while a finished result waits on out_stall as long as the input register
// is empty. There is no state beyond the pipeline registers.
module hex_lattice_gas_collision (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hlg_pkg::StateW-1:0]  cell_state,
  input  logic [hlg_pkg::RandW-1:0]   random_fraction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hlg_pkg::StateW-1:0]  new_state
);

  logic                       s1_valid;
  hlg_pkg::state_t            s1_cell;
  logic [hlg_pkg::RandW-1:0]  s1_rnd;
  logic                       s1_adv;
  logic                       out_free;

  hlg_pkg::cand_set_t         cand;
  logic [1:0]                 pick;
  hlg_pkg::state_t            new_state_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cell <= cell_state;
      s1_rnd  <= random_fraction;
    end
  end

  // Candidates are the class of the fully reversed state.
  assign cand = hlg_pkg::cand_of(hlg_pkg::reverse_state(s1_cell));

  // round(r*(n-1)), halves up: n=2 splits at 1/2, n=3 at 1/4 and 3/4.
  always_comb begin
    case (cand.n)
      2'd2: pick = {1'b0, s1_rnd[15]};
      2'd3: begin
        case (s1_rnd[15:14])
          2'b00:   pick = 2'd0;
          2'b11:   pick = 2'd2;
          default: pick = 2'd1;
        endcase
      end
      default: pick = 2'd0;
    endcase
  end

  always_comb begin
    case (pick)
      2'd1:    new_state_next = cand.c1;
      2'd2:    new_state_next = cand.c2;
      default: new_state_next = cand.c0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      new_state <= new_state_next;
    end
  end

  // Input side only backs up when both stages hold data.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("in_stall raised with pipeline not full");

  // Collision conserves particle count.
  a_count_kept: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> ($countones(new_state) == $countones($past(s1_cell))))
    else $error("particle count changed across collision");

  // Empty and full cells map to themselves.
  a_fixed_points: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (s1_cell == '0 || s1_cell == '1)) |=> (new_state == $past(s1_cell)))
    else $error("empty or full cell not kept");

endmodule

// ===== tb/sv/hlg_collision_checker.sv =====
// Checker for the hexagonal lattice gas collision block: predicts each new_state and compares.
`timescale 1ns / 100ps

module hlg_collision_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [hlg_pkg::StateW-1:0] cell_state,
  input  logic [hlg_pkg::RandW-1:0]  random_fraction,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [hlg_pkg::StateW-1:0] new_state,
  output int                         mismatches,
  output int                         outstanding
);
  import hlg_pkg::*;

  // per-direction momentum weights, directions in bit order
  localparam int DirX [6] = '{-100, -50, 50, 100, 50, -50};
  localparam int DirY [6] = '{0, 87, 87, 0, -87, -87};

  state_t collided_states[$];
  int     err_cnt = 0;

  function automatic void momentum(input state_t s, output int mx, output int my,
                                   output int cnt);
    mx = 0;
    my = 0;
    cnt = 0;
    for (int b = 0; b < 6; b++) begin
      if (s[b]) begin
        mx += DirX[b];
        my += DirY[b];
        cnt++;
      end
    end
  endfunction

  // Candidates: same count, negated momentum, ascending order. Index picked as
  // round(frac/65536 * (n-1)), halves up.
  function automatic state_t collide(input state_t occ, input logic [RandW-1:0] frac);
    int          cx, cy, cc, sx, sy, sc;
    int unsigned n, pick, seen;
    state_t      result;
    momentum(occ, cx, cy, cc);
    n = 0;
    result = occ;
    for (int s = 0; s < 64; s++) begin
      momentum(state_t'(s), sx, sy, sc);
      if (sc == cc && sx == -cx && sy == -cy) n++;
    end
    if (n == 0) n = 1;
    pick = (32'(frac) * (n - 1) + 32'd32768) >> 16;
    seen = 0;
    for (int s = 0; s < 64; s++) begin
      momentum(state_t'(s), sx, sy, sc);
      if (sc == cc && sx == -cx && sy == -cy) begin
        if (seen == pick) begin
          result = state_t'(s);
          break;
        end
        seen++;
      end
    end
    return result;
  endfunction

  always @(posedge clk) begin : monitor
    state_t want;
    if (!rst) begin
      if (in_valid && !in_stall) collided_states.push_back(collide(cell_state, random_fraction));
      if (out_valid && !out_stall) begin
        if (collided_states.size() == 0) begin
          $error("new_state: transfer with nothing expected, actual %0d", new_state);
          err_cnt++;
        end else begin
          want = collided_states.pop_front();
          if (new_state !== want) begin
            $error("new_state mismatch: expected %0d, actual %0d", want, new_state);
            err_cnt++;
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= collided_states.size();
  end

endmodule

// ===== tb/sv/tb_hex_lattice_gas_collision.sv =====
// Testbench top for the hexagonal lattice gas collision block: stimulus, flow control, verdict.
`timescale 1ns / 100ps

module tb_hex_lattice_gas_collision;
  import hlg_pkg::*;

  localparam int NumDirected   = 25;
  localparam int ItemsPerPhase = 250;
  localparam int NumPhases     = 4;
  localparam int HoldStart     = 150;
  localparam int HoldCycles    = 80;

  // cell, random fraction: extremes and both sides of every rounding step
  localparam int DirCell [NumDirected] = '{0, 63, 1, 9, 18, 36, 9, 18, 27, 45, 54, 21, 42,
                                           19, 37, 26, 44, 11, 38, 25, 52, 13, 22, 41, 50};
  localparam int DirFrac [NumDirected] = '{0, 65535, 65535, 0, 16383, 16384, 49151, 49152,
                                           65535, 32768, 0, 32767, 32768, 65535, 0, 32768,
                                           32767, 65535, 0, 32768, 32767, 65535, 0, 32768,
                                           12345};
  // members of the classes with more than one outcome
  localparam int MultiCell [20] = '{9, 18, 36, 27, 45, 54, 21, 42, 19, 37,
                                    26, 44, 11, 38, 25, 52, 13, 22, 41, 50};
  localparam int EdgeFrac [8] = '{0, 16383, 16384, 32767, 32768, 49151, 49152, 65535};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [StateW-1:0]  cell_state = '0;
  logic [RandW-1:0]   random_fraction = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StateW-1:0]  new_state;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accepted = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  hex_lattice_gas_collision dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cell_state      (cell_state),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_state       (new_state)
  );

  hlg_collision_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cell_state      (cell_state),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_state       (new_state),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off early on to back up the pipe.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) accepted <= accepted + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted >= HoldStart) begin
        out_stall <= 1'b1;
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic offer_cell(input int occ, input int frac);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    cell_state      <= StateW'(occ);
    random_fraction <= RandW'(frac);
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int occ, frac;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) offer_cell(DirCell[i], DirFrac[i]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if ($urandom_range(1)) occ = MultiCell[$urandom_range(19)];
        else occ = $urandom_range(63);
        if ($urandom_range(3) == 0) frac = EdgeFrac[$urandom_range(7)];
        else frac = $urandom_range(65535);
        offer_cell(occ, frac);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
